>>> rtl/core/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

    localparam int CAPACITY_DEFAULT = 32;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 6;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] element;
        logic               last;
    } result_t;

endpackage

>>> rtl/core/positional_list_engine.sv
// Top level of the positional list engine.
//
// Ordered list of up to CAPACITY signed 32-bit values held in a single-port-write,
// registered-read RAM. One command transaction on the s_ channel (op in s_tuser,
// value and position in s_tdata) yields result transactions on the m_ channel.
// Insert/delete ops give one result (status, new count, tlast set); dump gives one
// result per stored value in list order with tlast on the final one, or a single
// tlast result when the list is empty.
//
// A command that moves entries goes through S_SHIFT and S_DRAIN to S_FINISH; other
// insert/delete ops go straight to S_FINISH. Entries move one per cycle, read and written
// back through the RAM port pair, so a mid-list insert or delete shifts the list tail.
// Dump streams one value per cycle while m_tready is high, after a registered read of
// entry 0. One command is in flight at a time: s_tready is high only while idle.
//
// Reset clears the count, state and flags; the RAM contents are not cleared and
// need not be. When m_tready is low the result register holds and S_FINISH
// and S_DUMP wait; a finished result may wait while the next command is taken.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // value[31:0], position[37:32], zero[39:38]
    input  logic [OP_W-1:0]     s_tuser,   // op[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // status[1:0], count[7:2], element[39:8]
    output logic                m_tlast
);

    localparam int AW = $clog2(CAPACITY);

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    result_t            res;

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (s_tuser),
        .value     (s_tdata[VALUE_W-1:0]),
        .position  (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    ple_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign m_tdata = {res.element, res.count, res.status};
    assign m_tlast = res.last;

endmodule

>>> rtl/core/ple_ram.sv
// Entry store: one write port, one registered read port.
module ple_ram
    import ple_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [VALUE_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [VALUE_W-1:0] wr_data
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/ple_ctrl.sv
// Sequencer: decode, entry shifting through the store, dump and result register.
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int AW       = $clog2(CAPACITY)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    op,
    input  logic [VALUE_W-1:0] value,
    input  logic [POS_W-1:0]   position,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  logic [VALUE_W-1:0] rd_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [VALUE_W-1:0] wr_data,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_DUMP   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      end_reg, end_next;
    logic               up_reg, up_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               fin_wr_reg, fin_wr_next;
    logic [AW-1:0]      fin_addr_reg, fin_addr_next;
    logic [VALUE_W-1:0] fin_data_reg, fin_data_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               slot_free;
    logic               full, empty;
    logic [PW-1:0]      posx, nx, pos_m1;
    logic               ins_pos_ok, del_pos_ok;
    logic [CW-1:0]      n_m1, ptr_p1;
    logic [AW-1:0]      idx;
    logic               dump_last;

    always_comb
    begin
        slot_free  = !out_valid_reg || out_ready;
        full       = (count_reg == CAP_C);
        empty      = (count_reg == '0);
        posx       = PW'(position);
        nx         = PW'(count_reg);
        pos_m1     = posx - PW'(1);
        ins_pos_ok = (posx != '0) && (posx <= nx + PW'(1));
        del_pos_ok = (posx != '0) && (posx <= nx);
        n_m1       = count_reg - CW'(1);
        ptr_p1     = CW'(ptr_reg) + CW'(1);
        dump_last  = (ptr_p1 == count_reg);

        case (op)
            OP_INS_FRONT: idx = '0;
            OP_INS_BACK:  idx = count_reg[AW-1:0];
            OP_INS_POS:   idx = pos_m1[AW-1:0];
            OP_DEL_FRONT: idx = '0;
            OP_DEL_BACK:  idx = n_m1[AW-1:0];
            OP_DEL_POS:   idx = pos_m1[AW-1:0];
            default:      idx = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        up_next        = up_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        fin_wr_next    = fin_wr_reg;
        fin_addr_next  = fin_addr_reg;
        fin_data_next  = fin_data_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = rd_data;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = ST_OK;
                    fin_wr_next = 1'b0;
                    state_next  = S_FINISH;
                    case (op)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (op == OP_INS_POS && !ins_pos_ok)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                count_next    = count_reg + CW'(1);
                                fin_wr_next   = 1'b1;
                                fin_addr_next = idx;
                                fin_data_next = value;
                                if (CW'(idx) < count_reg)
                                begin
                                    ptr_next   = n_m1[AW-1:0];
                                    end_next   = idx;
                                    up_next    = 1'b0;
                                    pend_next  = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (op == OP_DEL_POS && !del_pos_ok)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                count_next = n_m1;
                                if (CW'(idx) + CW'(1) < count_reg)
                                begin
                                    ptr_next   = idx + AW'(1);
                                    end_next   = n_m1[AW-1:0];
                                    up_next    = 1'b1;
                                    pend_next  = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        OP_DUMP:
                        begin
                            if (!empty)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                rd_en          = 1'b1;
                rd_addr        = ptr_reg;
                wr_en          = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = up_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
                if (ptr_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = up_reg ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
                end
            end
            S_DRAIN:
            begin
                wr_en      = pend_reg;
                pend_next  = 1'b0;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    wr_en            = fin_wr_reg;
                    wr_addr          = fin_addr_reg;
                    wr_data          = fin_data_reg;
                    out_valid_next   = 1'b1;
                    out_next.status  = status_reg;
                    out_next.count   = CNT_W'(count_reg);
                    out_next.element = '0;
                    out_next.last    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.status  = ST_OK;
                    out_next.count   = CNT_W'(count_reg);
                    out_next.element = rd_data;
                    out_next.last    = dump_last;
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg + AW'(1);
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            fin_wr_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            fin_wr_reg    <= fin_wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        up_reg        <= up_next;
        pend_addr_reg <= pend_addr_next;
        fin_addr_reg  <= fin_addr_next;
        fin_data_reg  <= fin_data_next;
        status_reg    <= status_next;
        out_reg       <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

>>> rtl/core/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
module ple_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while a command is in flight");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[7:2] == CAP_CNT)
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_EMPTY |-> m_tdata[7:2] == '0)
        else $error("empty status with nonzero count");

    a_dump_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[1:0] == ST_OK)
        else $error("non-final result carries an error status");

endmodule

bind positional_list_engine ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
